/* rtl/pira_pkg.sv */
// Shared types and constants of the PI regulator with anti-windup.
package pira_pkg;

  localparam int GAIN_W  = 16;  // prop, rate and integrator gains
  localparam int SHIFT_W = 5;   // out_shift and integ_shift
  localparam int LIMIT_W = 31;  // integrator freeze limit
  localparam int INTEG_W = 32;  // integrator output
  localparam int SAT_W   = 2;
  localparam int IDX_W   = 3;

  typedef enum logic [SAT_W-1:0] {
    SAT_NONE = 2'd0,
    SAT_POS  = 2'd1,
    SAT_NEG  = 2'd2
  } sat_e;

  typedef enum logic {
    CMD_RUN   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_RATE_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_OUT_SHIFT   = 3'd3,
    REG_INTEG_SHIFT = 3'd4,
    REG_OUT_MIN     = 3'd5,
    REG_OUT_MAX     = 3'd6,
    REG_INTEG_LIMIT = 3'd7
  } reg_idx_e;

endpackage

/* rtl/pira_if.sv */
// Valid/ready channel interfaces for the regulator's input items and results.
interface pira_in_if #(
  parameter int SIGNAL_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [SIGNAL_WIDTH-1:0]    setpoint;
  logic signed [SIGNAL_WIDTH-1:0]    measured;
  logic signed [SIGNAL_WIDTH-1:0]    rate_in;
  logic        [pira_pkg::SAT_W-1:0] master_sat;

  modport source (output valid, command, setpoint, measured, rate_in, master_sat,
                  input ready);
  modport sink   (input valid, command, setpoint, measured, rate_in, master_sat,
                  output ready);
endinterface

interface pira_out_if #(
  parameter int SIGNAL_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [SIGNAL_WIDTH-1:0]      control_out;
  logic        [pira_pkg::SAT_W-1:0]   sat_code;
  logic signed [pira_pkg::INTEG_W-1:0] integ_out;

  modport source (output valid, control_out, sat_code, integ_out, input ready);
  modport sink   (input valid, control_out, sat_code, integ_out, output ready);
endinterface

/* rtl/pi_regulator_anti_windup.sv */
// PI regulator with rate term and integrator-clamping anti-windup, top level.
//
// Usage:
//   in_i  : one item per transfer: command (run / clear), setpoint, measured,
//           rate_in and the master saturation code.
//   out_o : one result per item: clamped control_out, sat_code, integ_out.
//   cfg   : cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
//           edge; write only while no item is in flight.
// Path: an item transfers into the input register, and its result is written
//   to the result register, where out_o.valid shows it until it transfers.
// Throughput: one item per cycle while out_o.ready is high. The whole step
//   (three multiplies, shift, clamp, saturation decision and accumulator
//   update) is a single pass of logic between the input and result registers;
//   the integrator state is written on the same edge, so the next item sees it at once.
// Reset: rst_ni clears the pipeline, the integrator state and loads the
//   register reset values (gains 0, shifts 0, full clamp range, full limit).
// Stall: while out_o.ready is low the result holds; the input register still
//   takes one more item, and in_i.ready drops once both stages are full.
// A clear command zeros the integrator state and returns an all-zero result.
module pi_regulator_anti_windup #(
  parameter int SIGNAL_WIDTH = 16,
  parameter int ACC_WIDTH    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                          cfg_we_i,
  input  logic [pira_pkg::IDX_W-1:0]                    cfg_idx_i,
  input  logic [((SIGNAL_WIDTH > pira_pkg::LIMIT_W) ?
                 SIGNAL_WIDTH : pira_pkg::LIMIT_W)-1:0]  cfg_data_i,

  pira_in_if.sink    in_i,
  pira_out_if.source out_o
);

  localparam int SW    = SIGNAL_WIDTH;
  localparam int AW    = ACC_WIDTH;
  localparam int GW    = pira_pkg::GAIN_W;
  localparam int SHW   = pira_pkg::SHIFT_W;
  localparam int LIMW  = pira_pkg::LIMIT_W;
  localparam int IVW   = pira_pkg::INTEG_W;
  localparam int EW    = SW + 1;                             // error
  localparam int PW    = ((EW > IVW) ? EW : IVW) + 2;        // proportional operand
  localparam int PPW   = PW + GW;                            // proportional product
  localparam int RPW   = SW + GW;                            // rate product
  localparam int SUMW  = PPW + 1;                            // control sum
  localparam int IW    = EW + GW;                            // integrator increment
  localparam int AXW   = ((AW > IW) ? AW : IW) + 1;          // exact accumulator sum
  localparam int LCW   = ((AW > LIMW) ? AW : LIMW) + 1;      // limit compare
  localparam int VW    = (AW > IVW) ? AW : IVW;              // shifted accumulator

  localparam logic signed [AW-1:0]  ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0]  ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [IVW-1:0] IV_MAX  = {1'b0, {(IVW-1){1'b1}}};
  localparam logic signed [IVW-1:0] IV_MIN  = {1'b1, {(IVW-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [GW-1:0]   prop_gain_q, rate_gain_q, integ_gain_q;
  logic        [SHW-1:0]  out_shift_q, integ_shift_q;
  logic signed [SW-1:0]   out_min_q, out_max_q;
  logic        [LIMW-1:0] integ_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      rate_gain_q   <= '0;
      integ_gain_q  <= '0;
      out_shift_q   <= '0;
      integ_shift_q <= '0;
      out_min_q     <= {1'b1, {(SW-1){1'b0}}};
      out_max_q     <= {1'b0, {(SW-1){1'b1}}};
      integ_limit_q <= '1;
    end else if (cfg_we_i) begin
      case (pira_pkg::reg_idx_e'(cfg_idx_i))
        pira_pkg::REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GW-1:0];
        pira_pkg::REG_RATE_GAIN:   rate_gain_q   <= cfg_data_i[GW-1:0];
        pira_pkg::REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GW-1:0];
        pira_pkg::REG_OUT_SHIFT:   out_shift_q   <= cfg_data_i[SHW-1:0];
        pira_pkg::REG_INTEG_SHIFT: integ_shift_q <= cfg_data_i[SHW-1:0];
        pira_pkg::REG_OUT_MIN:     out_min_q     <= cfg_data_i[SW-1:0];
        pira_pkg::REG_OUT_MAX:     out_max_q     <= cfg_data_i[SW-1:0];
        pira_pkg::REG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[LIMW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register in one step.
  // ---------------------------------------------------------------------------
  logic                        s1_vld_q;
  logic                        s1_cmd_q;
  logic signed [SW-1:0]        s1_sp_q, s1_meas_q, s1_rate_q;
  logic [pira_pkg::SAT_W-1:0]  s1_master_q;

  logic                        out_vld_q;
  logic signed [SW-1:0]        out_ctrl_q;
  pira_pkg::sat_e              out_sat_q;
  logic signed [IVW-1:0]       out_iv_q;

  logic signed [AW-1:0]        acc_q;
  logic signed [IVW-1:0]       iv_q;

  logic adv;     // result register can take a new value
  logic step;    // the item in the input register completes this cycle
  logic in_rdy;

  assign adv    = !out_vld_q || out_o.ready;
  assign step   = s1_vld_q && adv;
  assign in_rdy = !s1_vld_q || adv;

  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_rdy) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      s1_cmd_q    <= in_i.command;
      s1_sp_q     <= in_i.setpoint;
      s1_meas_q   <= in_i.measured;
      s1_rate_q   <= in_i.rate_in;
      s1_master_q <= in_i.master_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Control path: error, proportional and rate terms, shift and clamp.
  // ---------------------------------------------------------------------------
  logic signed [EW-1:0]   err;
  logic signed [PW-1:0]   psum;
  logic signed [PPW-1:0]  pprod;
  logic signed [RPW-1:0]  rprod;
  logic signed [SUMW-1:0] csum, csh, omin_x, omax_x;
  logic signed [SW-1:0]   ctrl;

  assign err   = EW'(s1_sp_q) - EW'(s1_meas_q);
  assign psum  = PW'(err) + PW'(iv_q) - PW'(s1_meas_q);
  assign pprod = PPW'(psum) * PPW'(prop_gain_q);
  assign rprod = RPW'(s1_rate_q) * RPW'(rate_gain_q);
  assign csum  = SUMW'(pprod) - SUMW'(rprod);
  assign csh   = csum >>> out_shift_q;

  assign omin_x = SUMW'(out_min_q);
  assign omax_x = SUMW'(out_max_q);

  // Upper bound is checked first: with crossed bounds it wins only above out_max.
  always_comb begin
    if (csh > omax_x) begin
      ctrl = out_max_q;
    end else if (csh < omin_x) begin
      ctrl = out_min_q;
    end else begin
      ctrl = csh[SW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Saturation decision: freeze the integrator when pushing into a limit.
  // ---------------------------------------------------------------------------
  logic signed [LCW-1:0] acc_x, lim_x, nlim_x;
  logic                  err_pos, err_neg;
  pira_pkg::sat_e        sat;

  assign acc_x   = LCW'(acc_q);
  assign lim_x   = LCW'(integ_limit_q);
  assign nlim_x  = -lim_x;
  assign err_neg = err[EW-1];
  assign err_pos = !err[EW-1] && (|err);

  always_comb begin
    if (err_pos && (ctrl >= out_max_q || acc_x > lim_x ||
                    s1_master_q == pira_pkg::SAT_POS)) begin
      sat = pira_pkg::SAT_POS;
    end else if (err_neg && (ctrl <= out_min_q || acc_x < nlim_x ||
                             s1_master_q == pira_pkg::SAT_NEG)) begin
      sat = pira_pkg::SAT_NEG;
    end else begin
      sat = pira_pkg::SAT_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Integrator: saturating accumulate, then shift and clip to 32 bits.
  // ---------------------------------------------------------------------------
  logic signed [IW-1:0]  inc;
  logic signed [AXW-1:0] asum;
  logic signed [AW-1:0]  acc_new;
  logic signed [VW-1:0]  vsh;
  logic signed [IVW-1:0] iv_new;

  assign inc  = IW'(err) * IW'(integ_gain_q);
  assign asum = AXW'(acc_q) + AXW'(inc);

  always_comb begin
    if (asum > AXW'(ACC_MAX)) begin
      acc_new = ACC_MAX;
    end else if (asum < AXW'(ACC_MIN)) begin
      acc_new = ACC_MIN;
    end else begin
      acc_new = asum[AW-1:0];
    end
  end

  assign vsh = VW'(acc_new) >>> integ_shift_q;

  always_comb begin
    if (vsh > VW'(IV_MAX)) begin
      iv_new = IV_MAX;
    end else if (vsh < VW'(IV_MIN)) begin
      iv_new = IV_MIN;
    end else begin
      iv_new = vsh[IVW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // State and result registers: both advance on the same step.
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0]  acc_d;
  logic signed [IVW-1:0] iv_d;

  always_comb begin
    acc_d = acc_q;
    iv_d  = iv_q;
    if (s1_cmd_q == pira_pkg::CMD_CLEAR) begin
      acc_d = '0;
      iv_d  = '0;
    end else if (sat == pira_pkg::SAT_NONE) begin
      acc_d = acc_new;
      iv_d  = iv_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      iv_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (step) begin
        acc_q <= acc_d;
        iv_q  <= iv_d;
      end
      if (adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      if (s1_cmd_q == pira_pkg::CMD_CLEAR) begin
        out_ctrl_q <= '0;
        out_sat_q  <= pira_pkg::SAT_NONE;
      end else begin
        out_ctrl_q <= ctrl;
        out_sat_q  <= sat;
      end
      out_iv_q <= iv_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.control_out = out_ctrl_q;
  assign out_o.sat_code    = out_sat_q;
  assign out_o.integ_out   = out_iv_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A clear step leaves the integrator empty.
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_cmd_q == pira_pkg::CMD_CLEAR |=> acc_q == '0 && iv_q == '0)
    else $error("integrator not cleared by clear command");

  // Anti-windup: a saturated run step must not move the accumulator.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_cmd_q == pira_pkg::CMD_RUN && sat != pira_pkg::SAT_NONE
    |=> $stable(acc_q) && $stable(iv_q))
    else $error("integrator moved while saturated");

  // Input backpressure only when a result is stalled behind a full input stage.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_vld_q && out_vld_q && !out_o.ready)
    else $error("input stalled without downstream stall");

  // The integrator output always reports the integrator state just written.
  a_iv_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_o.integ_out == iv_q)
    else $error("integ_out differs from integrator state");
`endif

endmodule

/* sim/pi_regulator_anti_windup_test.sv */
// Self-checking testbench for the PI regulator with anti-windup: predictor, stimulus, checks.
`timescale 1ns / 1ps

import pira_pkg::*;

localparam int     SIG_W      = 16;
localparam int     ACC_W      = 32;
localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
localparam longint ACC_BOTTOM = -ACC_TOP - 1;
// Master code with no meaning; the block treats it as none.
localparam logic [SAT_W-1:0] SAT_UNUSED = 2'd3;

typedef struct packed {
  cmd_e                     command;
  logic signed [SIG_W-1:0]  setpoint;
  logic signed [SIG_W-1:0]  measured;
  logic signed [SIG_W-1:0]  rate_in;
  logic        [SAT_W-1:0]  master_sat;
} step_t;

typedef struct packed {
  logic signed [SIG_W-1:0]   control_out;
  logic        [SAT_W-1:0]   sat_code;
  logic signed [INTEG_W-1:0] integ_out;
} result_t;

// Control law with its own register copy and integrator state.
class pi_law;
  logic signed [GAIN_W-1:0]  kp, kd, ki;
  logic        [SHIFT_W-1:0] out_sh, integ_sh;
  logic signed [SIG_W-1:0]   out_lo, out_hi;
  logic        [LIMIT_W-1:0] freeze_limit;
  longint                    acc, integ;
  sat_e                      last_sat;
  result_t                   due_results[$];
  int                        mismatch_count;

  function new();
    kp           = '0;
    kd           = '0;
    ki           = '0;
    out_sh       = '0;
    integ_sh     = '0;
    out_lo       = 16'sh8000;
    out_hi       = 16'sh7FFF;
    freeze_limit = '1;
    acc          = 0;
    integ        = 0;
    last_sat     = SAT_NONE;
    mismatch_count = 0;
  endfunction

  function void apply_reg(reg_idx_e idx, logic [LIMIT_W-1:0] data);
    case (idx)
      REG_PROP_GAIN:   kp = data[GAIN_W-1:0];
      REG_RATE_GAIN:   kd = data[GAIN_W-1:0];
      REG_INTEG_GAIN:  ki = data[GAIN_W-1:0];
      REG_OUT_SHIFT:   out_sh = data[SHIFT_W-1:0];
      REG_INTEG_SHIFT: integ_sh = data[SHIFT_W-1:0];
      REG_OUT_MIN:     out_lo = data[SIG_W-1:0];
      REG_OUT_MAX:     out_hi = data[SIG_W-1:0];
      REG_INTEG_LIMIT: freeze_limit = data;
      default: ;
    endcase
  endfunction

  // Advance the regulator by one accepted item and queue its result.
  function void take_step(step_t s);
    longint  err, total, ctrl, lo, hi, lim, sum;
    sat_e    code;
    result_t r;
    if (s.command == CMD_CLEAR) begin
      acc      = 0;
      integ    = 0;
      last_sat = SAT_NONE;
      r        = '0;
      due_results.push_back(r);
      return;
    end
    lo    = longint'(out_lo);
    hi    = longint'(out_hi);
    lim   = longint'(freeze_limit);
    err   = longint'(s.setpoint) - longint'(s.measured);
    total = (err + integ - longint'(s.measured)) * longint'(kp)
            - longint'(s.rate_in) * longint'(kd);
    ctrl  = total >>> out_sh;
    // Upper bound is checked first: with crossed bounds it wins only above hi.
    if (ctrl > hi)
      ctrl = hi;
    else if (ctrl < lo)
      ctrl = lo;

    if (err > 0 && (ctrl >= hi || acc > lim || s.master_sat == SAT_POS))
      code = SAT_POS;
    else if (err < 0 && (ctrl <= lo || acc < -lim || s.master_sat == SAT_NEG))
      code = SAT_NEG;
    else
      code = SAT_NONE;
    last_sat = code;

    if (code == SAT_NONE) begin
      sum = acc + err * longint'(ki);
      if (sum > ACC_TOP)
        sum = ACC_TOP;
      else if (sum < ACC_BOTTOM)
        sum = ACC_BOTTOM;
      acc   = sum;
      integ = acc >>> integ_sh;
    end

    r.control_out = ctrl[SIG_W-1:0];
    r.sat_code    = code;
    r.integ_out   = integ[INTEG_W-1:0];
    due_results.push_back(r);
  endfunction

  function void compare_output(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result with nothing due: control_out %0d sat_code %0d integ_out %0d",
                 got.control_out, got.sat_code, got.integ_out);
      return;
    end
    want = due_results.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result mismatch: control_out %0d/%0d sat_code %0d/%0d integ_out %0d/%0d",
                 want.control_out, got.control_out, want.sat_code, got.sat_code,
                 want.integ_out, got.integ_out);
    end
  endfunction
endclass

module pi_regulator_anti_windup_test;

  localparam int QUIET_LIMIT = 500;  // cycles without any transfer before giving up
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_idx;
  logic [LIMIT_W-1:0]   cfg_data;

  pira_in_if  #(.SIGNAL_WIDTH(SIG_W)) in_bus ();
  pira_out_if #(.SIGNAL_WIDTH(SIG_W)) out_bus ();

  pi_law law;
  bit    steady_flow;  // no gaps and no stalls while set
  int    quiet_cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pi_regulator_anti_windup #(
    .SIGNAL_WIDTH(SIG_W),
    .ACC_WIDTH   (ACC_W)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  // ---------------------------------------------------------------------------
  // Random field helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SIG_W-1:0] pick_signal();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3, 4: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return 16'(int'($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: present one item, hold it until the transfer, then record it.
  // Called at a rising edge; returns at the edge of the transfer.
  // ---------------------------------------------------------------------------
  task automatic run_step(cmd_e c, logic signed [SIG_W-1:0] sp,
                          logic signed [SIG_W-1:0] meas, logic signed [SIG_W-1:0] rate,
                          logic [SAT_W-1:0] ms);
    step_t s;
    int    gap;
    s   = '{command: c, setpoint: sp, measured: meas, rate_in: rate, master_sat: ms};
    gap = draw_wait();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.command    <= s.command;
    in_bus.setpoint   <= s.setpoint;
    in_bus.measured   <= s.measured;
    in_bus.rate_in    <= s.rate_in;
    in_bus.master_sat <= s.master_sat;
    do @(posedge clk_i); while (!in_bus.ready);
    law.take_step(s);
  endtask

  task automatic run_random_step();
    logic signed [SIG_W-1:0] sp, meas, rate;
    logic [SAT_W-1:0]        ms;
    cmd_e                    c;
    c  = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_RUN;
    sp = pick_signal();
    // Mostly track the setpoint closely so the integrator sees small errors.
    if ($urandom_range(0, 2) != 0)
      meas = 16'(int'(sp) + int'($urandom_range(0, 64)) - 32);
    else
      meas = pick_signal();
    rate = $urandom_range(0, 1) ? pick_signal() : '0;
    ms   = $urandom_range(0, 1) ? SAT_NONE : SAT_W'($urandom_range(SAT_NONE, SAT_UNUSED));
    run_step(c, sp, meas, rate, ms);
  endtask

  // Drop valid, wait for every due result, then let the pipeline go quiet.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (law.due_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all registers, one per clock, mirroring each into the predictor.
  task automatic load_settings(logic signed [GAIN_W-1:0] kp, logic signed [GAIN_W-1:0] kd,
                               logic signed [GAIN_W-1:0] ki, logic [SHIFT_W-1:0] osh,
                               logic [SHIFT_W-1:0] ish, logic signed [SIG_W-1:0] lo,
                               logic signed [SIG_W-1:0] hi, logic [LIMIT_W-1:0] limit);
    logic [LIMIT_W-1:0] word [REG_PROP_GAIN:REG_INTEG_LIMIT];
    reg_idx_e           idx;
    word[REG_PROP_GAIN]   = LIMIT_W'(kp);
    word[REG_RATE_GAIN]   = LIMIT_W'(kd);
    word[REG_INTEG_GAIN]  = LIMIT_W'(ki);
    word[REG_OUT_SHIFT]   = LIMIT_W'(osh);
    word[REG_INTEG_SHIFT] = LIMIT_W'(ish);
    word[REG_OUT_MIN]     = LIMIT_W'(lo);
    word[REG_OUT_MAX]     = LIMIT_W'(hi);
    word[REG_INTEG_LIMIT] = limit;
    for (int i = REG_PROP_GAIN; i <= REG_INTEG_LIMIT; i++) begin
      idx = reg_idx_e'(i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= word[idx];
      @(posedge clk_i);
      law.apply_reg(idx, word[idx]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_settings();
    logic signed [SIG_W-1:0] a, b, lo, hi;
    logic [LIMIT_W-1:0]      limit;
    a = pick_signal();
    b = pick_signal();
    case ($urandom_range(0, 5))
      0: begin
        lo = 16'sh8000;
        hi = 16'sh7FFF;
      end
      1: begin  // crossed bounds
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    case ($urandom_range(0, 3))
      0:       limit = '0;
      1:       limit = '1;
      2:       limit = LIMIT_W'($urandom_range(0, 1 << 20));
      default: limit = LIMIT_W'($urandom);
    endcase
    load_settings(pick_gain(), pick_gain(), pick_gain(),
                  $urandom_range(0, 1) ? SHIFT_W'($urandom_range(0, 12))
                                       : SHIFT_W'($urandom_range(0, 31)),
                  SHIFT_W'($urandom_range(0, 31)), lo, hi, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed items, random phases, final verdict
  // ---------------------------------------------------------------------------
  initial begin
    law = new();
    steady_flow = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_PROP_GAIN;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.command    <= CMD_RUN;
    in_bus.setpoint   <= '0;
    in_bus.measured   <= '0;
    in_bus.rate_in    <= '0;
    in_bus.master_sat <= SAT_NONE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: all gains zero.
    run_step(CMD_RUN, 16'sd1200, -16'sd300, 16'sd50, SAT_NONE);
    run_step(CMD_RUN, -16'sd900, 16'sd40, 16'sd0, SAT_NONE);
    settle();

    // Moderate gains: field extremes, every master code, zero error, clear.
    load_settings(16'sd3, 16'sd2, 16'sd5, 5'd2, 5'd4, -16'sd1000, 16'sd1000, 31'd100000);
    run_step(CMD_RUN, 16'sd100, 16'sd0, 16'sd0, SAT_NONE);
    run_step(CMD_RUN, 16'sh7FFF, 16'sh8000, 16'sh7FFF, SAT_NONE);
    run_step(CMD_RUN, 16'sh8000, 16'sh7FFF, 16'sh8000, SAT_NONE);
    run_step(CMD_RUN, 16'sd50, 16'sd10, 16'sd0, SAT_POS);
    run_step(CMD_RUN, -16'sd50, 16'sd10, 16'sd0, SAT_NEG);
    run_step(CMD_RUN, 16'sd50, 16'sd10, 16'sd0, SAT_UNUSED);
    run_step(CMD_RUN, -16'sd50, 16'sd10, 16'sd5, SAT_POS);
    run_step(CMD_RUN, 16'sd7, 16'sd7, -16'sd3, SAT_NONE);
    run_step(CMD_CLEAR, 16'sd1234, -16'sd77, 16'sd9, SAT_NEG);
    run_step(CMD_RUN, 16'sd20, -16'sd20, 16'sd100, SAT_NONE);
    settle();

    // Extreme gains, no shift, zero freeze limit.
    load_settings(16'sh7FFF, 16'sh8000, 16'sh7FFF, 5'd0, 5'd0, 16'sh8000, 16'sh7FFF, '0);
    run_step(CMD_RUN, 16'sd1, 16'sd0, 16'sd0, SAT_NONE);
    run_step(CMD_RUN, 16'sh8000, 16'sh7FFF, 16'sh7FFF, SAT_NONE);
    run_step(CMD_RUN, 16'sh7FFF, 16'sh8000, 16'sh8000, SAT_NONE);
    settle();

    // Pure integrator at full gain: drive the accumulator into both rails.
    load_settings('0, '0, 16'sh7FFF, 5'd31, 5'd31, 16'sh8000, 16'sh7FFF, '1);
    repeat (3) run_step(CMD_RUN, 16'sh7FFF, 16'sh8000, 16'sd0, SAT_NONE);
    repeat (3) run_step(CMD_RUN, 16'sh8000, 16'sh7FFF, 16'sd0, SAT_NONE);
    settle();

    // Crossed clamp bounds: above, below and between.
    load_settings(16'sd1, '0, '0, 5'd0, 5'd0, 16'sd500, -16'sd500, '1);
    run_step(CMD_RUN, 16'sd1000, 16'sd0, 16'sd0, SAT_NONE);
    run_step(CMD_RUN, -16'sd1000, 16'sd0, 16'sd0, SAT_NONE);
    run_step(CMD_RUN, 16'sd0, 16'sd0, 16'sd0, SAT_NONE);
    settle();

    // Random phases, each under fresh register values; some without idling.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      load_random_settings();
      steady_flow = (phase % 4 == 1);
      repeat (PHASE_ITEMS) run_random_step();
      settle();
    end
    steady_flow = 1'b0;
    repeat (10) @(posedge clk_i);

    if (law.mismatch_count == 0 && law.due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: stall at random, check each result transfer
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int      stall;
    result_t got;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      got.control_out = out_bus.control_out;
      got.sat_code    = out_bus.sat_code;
      got.integ_out   = out_bus.integ_out;
      law.compare_output(got);
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      quiet_cycles = 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
rtl/pira_pkg.sv
rtl/pira_if.sv
rtl/pi_regulator_anti_windup.sv
sim/pi_regulator_anti_windup_test.sv
